// ----- hw/rtl/rrtd_pkg.sv -----
// Shared types, constants and helpers for the run-length row texel decoder.
package rrtd_pkg;

	localparam int MAX_EDGE      = 1024;
	localparam int MAX_ROW_BYTES = 8192;
	localparam int EDGE_W        = 11;
	localparam int POS_W         = 10;
	localparam int RBL_W         = 14;
	localparam int PEND_W        = 7;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 11;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = 2;
	localparam int QUEUE_CW      = 3;

	typedef enum logic [2:0] {
		PH_LO,
		PH_HI,
		PH_CODE,
		PH_REPVAL,
		PH_LIT,
		PH_DRAIN,
		PH_ERR,
		PH_DONE
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_KEY,
		REG_MODE
	} cfg_reg_t;

	typedef struct packed {
		logic [EDGE_W-1:0] width;
		logic [EDGE_W-1:0] height;
		logic [7:0]        key;
		logic              compressed;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  column;
		logic [EDGE_W-1:0] length;
		logic [7:0]        value;
		logic              done;
		logic              err;
	} run_t;

	typedef struct packed {
		logic [1:0] n;
		run_t       r0;
		run_t       r1;
	} push_t;

	// Zero reads as one, anything above the largest edge as the largest edge.
	function automatic logic [EDGE_W-1:0] clamp_edge(input logic [EDGE_W-1:0] v);
		logic [EDGE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = EDGE_W'(1);
		end else if (v > EDGE_W'(MAX_EDGE)) begin
			r = EDGE_W'(MAX_EDGE);
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/rrtd_in_if.sv -----
// Byte stream channel into the decoder.
interface rrtd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// ----- hw/rtl/rrtd_out_if.sv -----
// Texel run channel out of the decoder.
interface rrtd_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  run_row;
	logic [9:0]  run_column;
	logic [10:0] run_length;
	logic [7:0]  texel_value;
	logic        frame_done;
	logic        decode_error;

	modport source (output valid, output run_row, output run_column, output run_length,
		output texel_value, output frame_done, output decode_error, input ready);
	modport sink (input valid, input run_row, input run_column, input run_length,
		input texel_value, input frame_done, input decode_error, output ready);
endinterface

// ----- hw/rtl/rrtd_cfg_if.sv -----
// Register write channel of the decoder.
interface rrtd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rrtd_pkg::CFG_IDX_W-1:0]  index;
	logic [rrtd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/rrtd_parser.sv -----
// Input register, parser state and per-byte decode into at most two runs.
module rrtd_parser (
	input  logic             clk,
	input  logic             arst_n,
	rrtd_in_if.sink          stream,
	input  rrtd_pkg::cfg_t   cfg,
	input  logic             room,
	output rrtd_pkg::push_t  push
);

	logic [7:0] byte_s1;
	logic       start_s1;
	logic       valid_s1;
	logic       consume;

	rrtd_pkg::phase_t                 phase_q, phase_d;
	logic [rrtd_pkg::EDGE_W-1:0]      row_q, row_d;
	logic [rrtd_pkg::EDGE_W-1:0]      col_q, col_d;
	logic [rrtd_pkg::RBL_W-1:0]       rbl_q, rbl_d;
	logic [7:0]                       lo_q, lo_d;
	logic [rrtd_pkg::PEND_W-1:0]      pend_q, pend_d;
	rrtd_pkg::push_t                  res;

	assign consume      = valid_s1 && room;
	assign stream.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1  <= stream.data_byte;
			start_s1 <= stream.frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rrtd_pkg::PH_LO;
			row_q   <= '0;
			col_q   <= '0;
			rbl_q   <= '0;
			lo_q    <= '0;
			pend_q  <= '0;
		end else if (consume) begin
			phase_q <= phase_d;
			row_q   <= row_d;
			col_q   <= col_d;
			rbl_q   <= rbl_d;
			lo_q    <= lo_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		rrtd_pkg::phase_t             ph;
		logic [rrtd_pkg::EDGE_W-1:0]  row, col, col_base, avail, len_a, col1, len_b;
		logic [rrtd_pkg::EDGE_W-1:0]  row_r, col_r;
		logic [rrtd_pkg::RBL_W-1:0]   rbl, rbl_dec;
		logic [7:0]                   lo, val_a;
		logic [rrtd_pkg::PEND_W-1:0]  pend, want;
		logic [15:0]                  cnt;
		logic [rrtd_pkg::EDGE_W:0]    sum_a;
		logic                         last_row, tail, end_row, emit_a, emit_b, dead;
		rrtd_pkg::run_t               run_a, run_b;

		// a frame start clears the parser before its byte is used
		ph   = start_s1 ? rrtd_pkg::PH_LO : phase_q;
		row  = start_s1 ? '0 : row_q;
		col  = start_s1 ? '0 : col_q;
		rbl  = start_s1 ? '0 : rbl_q;
		lo   = start_s1 ? '0 : lo_q;
		pend = start_s1 ? '0 : pend_q;

		phase_d = ph;
		row_d   = row;
		col_d   = col;
		rbl_d   = rbl;
		lo_d    = lo;
		pend_d  = pend;
		res     = '0;

		last_row = ({1'b0, row} + 12'd1) >= {1'b0, cfg.height};
		col_base = col;
		want     = '0;
		val_a    = cfg.key;
		tail     = 1'b0;
		end_row  = 1'b0;
		rbl_dec  = (rbl != '0) ? rbl - 1'b1 : '0;
		cnt      = {byte_s1, lo};
		row_r    = row;
		col_r    = col;
		dead     = 1'b0;

		if (ph == rrtd_pkg::PH_ERR || ph == rrtd_pkg::PH_DONE) begin
			// drop everything until the next frame start
		end else if (!cfg.compressed) begin
			if (col >= cfg.width) begin
				col_r = '0;
				row_r = row + 1'b1;
				if (row_r >= cfg.height) begin
					phase_d = rrtd_pkg::PH_DONE;
					dead    = 1'b1;
				end
			end
			if (!dead) begin
				res.n         = 2'd1;
				res.r0.row    = row_r[rrtd_pkg::POS_W-1:0];
				res.r0.column = col_r[rrtd_pkg::POS_W-1:0];
				res.r0.length = rrtd_pkg::EDGE_W'(1);
				res.r0.value  = byte_s1;
				res.r0.done   = (({1'b0, row_r} + 12'd1) >= {1'b0, cfg.height})
					&& (({1'b0, col_r} + 12'd1) >= {1'b0, cfg.width});
				col_r = col_r + 1'b1;
				if (col_r >= cfg.width) begin
					col_r = '0;
					row_r = row_r + 1'b1;
					if (row_r >= cfg.height) begin
						phase_d = rrtd_pkg::PH_DONE;
					end
				end
			end
			row_d = row_r;
			col_d = col_r;
		end else begin
			unique case (ph)
				rrtd_pkg::PH_LO: begin
					lo_d    = byte_s1;
					phase_d = rrtd_pkg::PH_HI;
				end
				rrtd_pkg::PH_HI: begin
					if (cnt > 16'(rrtd_pkg::MAX_ROW_BYTES)) begin
						phase_d       = rrtd_pkg::PH_ERR;
						res.n         = 2'd1;
						res.r0.row    = row[rrtd_pkg::POS_W-1:0];
						res.r0.done   = 1'b1;
						res.r0.err    = 1'b1;
					end else if (cnt == 16'd0) begin
						col_base = '0;
						end_row  = 1'b1;
					end else begin
						col_d   = '0;
						rbl_d   = cnt[rrtd_pkg::RBL_W-1:0];
						phase_d = rrtd_pkg::PH_CODE;
					end
				end
				rrtd_pkg::PH_CODE: begin
					tail = 1'b1;
					if (byte_s1[0]) begin
						want = byte_s1[7:1];
					end else begin
						pend_d  = rrtd_pkg::PEND_W'(byte_s1[7:2]) + 1'b1;
						phase_d = byte_s1[1] ? rrtd_pkg::PH_REPVAL : rrtd_pkg::PH_LIT;
					end
				end
				rrtd_pkg::PH_REPVAL: begin
					tail    = 1'b1;
					want    = pend;
					val_a   = byte_s1;
					pend_d  = '0;
					phase_d = rrtd_pkg::PH_CODE;
				end
				rrtd_pkg::PH_LIT: begin
					tail   = 1'b1;
					want   = rrtd_pkg::PEND_W'(1);
					val_a  = byte_s1;
					pend_d = (pend != '0) ? pend - 1'b1 : '0;
					if (pend_d == '0) begin
						phase_d = rrtd_pkg::PH_CODE;
					end
				end
				default: begin
					tail = 1'b1;
				end
			endcase
		end

		// clipped run at the current column
		avail  = (col_base < cfg.width) ? cfg.width - col_base : '0;
		len_a  = ({4'b0, want} < avail) ? {4'b0, want} : avail;
		emit_a = len_a != '0;
		sum_a  = {1'b0, col_base} + {1'b0, len_a};
		col1   = col_base + len_a;

		run_a.row    = row[rrtd_pkg::POS_W-1:0];
		run_a.column = col_base[rrtd_pkg::POS_W-1:0];
		run_a.length = len_a;
		run_a.value  = val_a;
		run_a.done   = last_row && (sum_a >= {1'b0, cfg.width});
		run_a.err    = 1'b0;

		if (tail) begin
			rbl_d = rbl_dec;
			if (rbl_dec == '0) begin
				end_row = 1'b1;
			end else begin
				col_d = col1;
				if (col1 >= cfg.width) begin
					phase_d = rrtd_pkg::PH_DRAIN;
				end
			end
		end

		// key fill for whatever the row left uncovered
		emit_b       = end_row && (col1 < cfg.width);
		len_b        = cfg.width - col1;
		run_b.row    = row[rrtd_pkg::POS_W-1:0];
		run_b.column = col1[rrtd_pkg::POS_W-1:0];
		run_b.length = len_b;
		run_b.value  = cfg.key;
		run_b.done   = last_row;
		run_b.err    = 1'b0;

		if (end_row) begin
			col_d   = '0;
			rbl_d   = '0;
			pend_d  = '0;
			row_d   = row + 1'b1;
			phase_d = last_row ? rrtd_pkg::PH_DONE : rrtd_pkg::PH_LO;
		end

		if (tail || end_row) begin
			if (emit_a) begin
				res.n  = emit_b ? 2'd2 : 2'd1;
				res.r0 = run_a;
				res.r1 = run_b;
			end else begin
				res.n  = emit_b ? 2'd1 : 2'd0;
				res.r0 = run_b;
			end
		end
	end

	always_comb begin
		push   = res;
		push.n = consume ? res.n : 2'd0;
	end

	// an error result stands alone and closes the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0 && push.r0.err) |-> (push.n == 2'd1 && push.r0.done))
		else $error("error result not alone or not marked done");

	// nothing comes out of a frame that has failed
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !start_s1 && phase_q == rrtd_pkg::PH_ERR) |-> push.n == 2'd0)
		else $error("run emitted after decode error");

	// the second run of a byte is always the row's key fill
	assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> (push.r1.value == cfg.key && !push.r1.err && push.r0.length != '0))
		else $error("second run is not a key fill");

endmodule

// ----- hw/rtl/rrtd_queue.sv -----
// Result queue: takes up to two runs per cycle while it has room, hands out one per cycle while the runs side is ready.
module rrtd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  rrtd_pkg::push_t  push,
	output logic             room,
	rrtd_out_if.source       runs
);

	rrtd_pkg::run_t                 entry_q [rrtd_pkg::QUEUE_DEPTH];
	logic [rrtd_pkg::QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [rrtd_pkg::QUEUE_CW-1:0]  count_q;
	logic                           pop;
	rrtd_pkg::run_t                 head;

	assign room = count_q <= rrtd_pkg::QUEUE_CW'(rrtd_pkg::QUEUE_DEPTH - 2);
	assign pop  = runs.valid && runs.ready;
	assign head = entry_q[rd_ptr_q];

	assign runs.valid        = count_q != '0;
	assign runs.run_row      = head.row;
	assign runs.run_column   = head.column;
	assign runs.run_length   = head.length;
	assign runs.texel_value  = head.value;
	assign runs.frame_done   = head.done;
	assign runs.decode_error = head.err;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			entry_q[wr_ptr_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + rrtd_pkg::QUEUE_AW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + rrtd_pkg::QUEUE_CW'(push.n) - rrtd_pkg::QUEUE_CW'(pop);
		end
	end

	// the parser only pushes when two free slots were seen
	assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("push into a full result queue");

	// the fill level follows pushes and pops exactly
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + rrtd_pkg::QUEUE_CW'($past(push.n))
			- rrtd_pkg::QUEUE_CW'($past(pop)))
		else $error("result queue count slipped");

endmodule

// ----- hw/rtl/rle_row_texel_decoder_top.sv -----
// Top level of the run-length row texel decoder: registers, parser and result queue.
//
// The decoder takes a frame's pixel stream one byte per cycle on the stream
// channel and hands out texel runs (row, start column, length, palette
// index) on the runs channel; the runs of each row tile it left to right.
// A byte makes zero, one or two runs. Every byte passes an input register
// and is decoded into a four-entry result queue; a run is offered on the
// runs channel once its byte has passed the input register and has been
// written into the queue. With the runs side always ready the block takes
// a byte every cycle; the second run of a byte that yields two runs (a code
// that also closes its row) leaves the queue after the first, and the
// stream stalls once the queue holds more than two runs. There is
// no clearing pass after reset. Registers are written through the cfg
// channel, which is always ready: width and height are clamped to
// 1..1024 as they are written. Write them only while the block is idle.
module rle_row_texel_decoder_top (
	input  logic         clk,
	input  logic         arst_n,
	rrtd_cfg_if.sink     cfg,
	rrtd_in_if.sink      stream,
	rrtd_out_if.source   runs
);

	rrtd_pkg::cfg_t   cfg_q;
	rrtd_pkg::push_t  push;
	logic             room;

	// registers never stall
	assign cfg.ready = 1'b1;

	// hold the register file; store width and height already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width      <= rrtd_pkg::EDGE_W'(1);
			cfg_q.height     <= rrtd_pkg::EDGE_W'(1);
			cfg_q.key        <= '0;
			cfg_q.compressed <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (rrtd_pkg::cfg_reg_t'(cfg.index))
				rrtd_pkg::REG_WIDTH:  cfg_q.width      <= rrtd_pkg::clamp_edge(cfg.data);
				rrtd_pkg::REG_HEIGHT: cfg_q.height     <= rrtd_pkg::clamp_edge(cfg.data);
				rrtd_pkg::REG_KEY:    cfg_q.key        <= cfg.data[7:0];
				rrtd_pkg::REG_MODE:   cfg_q.compressed <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// decode each byte against the current parser state
	rrtd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.cfg    (cfg_q),
		.room   (room),
		.push   (push)
	);

	// buffer the runs so a stalled consumer does not stop the stream at once
	rrtd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.runs   (runs)
	);

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the run-length row texel decoder: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps

module tb;

	// Stop criteria and timing margins.
	localparam int ITEM_TARGET  = 1150;
	localparam int SETTLE_TICKS = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_MAX   = 10;

	// One byte of the pixel stream together with its frame start mark.
	typedef struct packed {
		logic       fs;
		logic [7:0] b;
	} stream_byte_t;

	// Predicts the texel runs of the decoder and matches them against what comes out.
	class run_tracker;
		logic [rrtd_pkg::EDGE_W-1:0] width_reg;
		logic [rrtd_pkg::EDGE_W-1:0] height_reg;
		logic [7:0]                  key_reg;
		logic                        rle_mode;
		rrtd_pkg::phase_t            ph;
		int                          row;
		int                          col;
		int                          left;
		int                          lo_byte;
		int                          pend;
		rrtd_pkg::run_t              pending_runs[$];
		int                          fails;

		function new();
			width_reg  = rrtd_pkg::EDGE_W'(1);
			height_reg = rrtd_pkg::EDGE_W'(1);
			key_reg    = 8'd0;
			rle_mode   = 1'b1;
			fails      = 0;
			clear_parser();
		endfunction

		function void clear_parser();
			ph      = rrtd_pkg::PH_LO;
			row     = 0;
			col     = 0;
			left    = 0;
			lo_byte = 0;
			pend    = 0;
		endfunction

		function int fit_edge(input logic [rrtd_pkg::EDGE_W-1:0] v);
			if (v == '0) return 1;
			if (v > rrtd_pkg::EDGE_W'(rrtd_pkg::MAX_EDGE)) return rrtd_pkg::MAX_EDGE;
			return int'(v);
		endfunction

		function void set_reg(input rrtd_pkg::cfg_reg_t idx,
				input logic [rrtd_pkg::CFG_DATA_W-1:0] v);
			case (idx)
			rrtd_pkg::REG_WIDTH: width_reg = v;
			rrtd_pkg::REG_HEIGHT: height_reg = v;
			rrtd_pkg::REG_KEY: key_reg = v[7:0];
			default: rle_mode = v[0];
			endcase
		endfunction

		function void add_run(input int len, input logic [7:0] val, input int w, input int h);
			rrtd_pkg::run_t r;
			r.row    = rrtd_pkg::POS_W'(row);
			r.column = rrtd_pkg::POS_W'(col);
			r.length = rrtd_pkg::EDGE_W'(len);
			r.value  = val;
			r.done   = (row + 1 >= h) && (col + len >= w);
			r.err    = 1'b0;
			pending_runs.push_back(r);
		endfunction

		// Clip the run at the row's end, then advance the column.
		function void clipped_run(input int want, input logic [7:0] val, input int w, input int h);
			int avail;
			int len;
			avail = (col < w) ? w - col : 0;
			len = (want < avail) ? want : avail;
			if (len > 0) begin
				add_run(len, val, w, h);
				col += len;
			end
		endfunction

		// Fill the rest of the row with the key colour and move to the next row.
		function void close_row(input int w, input int h);
			if (col < w) add_run(w - col, key_reg, w, h);
			col  = 0;
			left = 0;
			pend = 0;
			row++;
			ph = (row >= h) ? rrtd_pkg::PH_DONE : rrtd_pkg::PH_LO;
		endfunction

		function void take_byte(input logic [7:0] b, input logic fs);
			int             w;
			int             h;
			int             cnt;
			rrtd_pkg::run_t r;
			w = fit_edge(width_reg);
			h = fit_edge(height_reg);
			if (fs) clear_parser();
			if (ph == rrtd_pkg::PH_ERR || ph == rrtd_pkg::PH_DONE) return;

			if (!rle_mode) begin
				if (col >= w) begin
					col = 0;
					row++;
					if (row >= h) begin
						ph = rrtd_pkg::PH_DONE;
						return;
					end
				end
				add_run(1, b, w, h);
				col++;
				if (col >= w) begin
					col = 0;
					row++;
					if (row >= h) ph = rrtd_pkg::PH_DONE;
				end
				return;
			end

			case (ph)
			rrtd_pkg::PH_LO: begin
				lo_byte = int'(b);
				ph = rrtd_pkg::PH_HI;
				return;
			end
			rrtd_pkg::PH_HI: begin
				cnt = lo_byte | (int'(b) << 8);
				if (cnt > rrtd_pkg::MAX_ROW_BYTES) begin
					ph = rrtd_pkg::PH_ERR;
					r = '0;
					r.row  = rrtd_pkg::POS_W'(row);
					r.done = 1'b1;
					r.err  = 1'b1;
					pending_runs.push_back(r);
					return;
				end
				col = 0;
				if (cnt == 0) begin
					close_row(w, h);
					return;
				end
				left = cnt;
				ph = rrtd_pkg::PH_CODE;
				return;
			end
			rrtd_pkg::PH_CODE: begin
				if (left > 0) left--;
				if (b[0]) begin
					clipped_run(int'(b >> 1), key_reg, w, h);
				end else begin
					pend = int'(b >> 2) + 1;
					ph = b[1] ? rrtd_pkg::PH_REPVAL : rrtd_pkg::PH_LIT;
				end
			end
			rrtd_pkg::PH_REPVAL: begin
				if (left > 0) left--;
				clipped_run(pend, b, w, h);
				pend = 0;
				ph = rrtd_pkg::PH_CODE;
			end
			rrtd_pkg::PH_LIT: begin
				if (left > 0) left--;
				clipped_run(1, b, w, h);
				if (pend > 0) pend--;
				if (pend == 0) ph = rrtd_pkg::PH_CODE;
			end
			default: begin
				if (left > 0) left--;
			end
			endcase

			if (left == 0) close_row(w, h);
			else if (col >= w) ph = rrtd_pkg::PH_DRAIN;
		endfunction

		function string describe(input rrtd_pkg::run_t r);
			return $sformatf("row %0d col %0d len %0d val 0x%02h done %0b err %0b",
				r.row, r.column, r.length, r.value, r.done, r.err);
		endfunction

		function void match_run(input rrtd_pkg::run_t got);
			rrtd_pkg::run_t exp_run;
			if (pending_runs.size() == 0) begin
				if (fails < REPORT_MAX) $display("unexpected run: %s", describe(got));
				fails++;
				return;
			end
			exp_run = pending_runs.pop_front();
			if (got.row !== exp_run.row || got.column !== exp_run.column ||
					got.length !== exp_run.length || got.value !== exp_run.value ||
					got.done !== exp_run.done || got.err !== exp_run.err) begin
				if (fails < REPORT_MAX) begin
					$display("run mismatch: expected %s, got %s",
						describe(exp_run), describe(got));
				end
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rrtd_cfg_if cfg_ch ();
	rrtd_in_if  in_ch ();
	rrtd_out_if out_ch ();

	rle_row_texel_decoder_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.stream (in_ch),
		.runs   (out_ch)
	);

	run_tracker   tracker = new;
	stream_byte_t plan[$];
	bit           calm_src;
	bit           calm_sink;
	int           bytes_taken;
	int           cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run: a hang in either handshake ends here.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Runs side: check every accepted item, and stall ready at random.
	initial begin
		int             hold;
		rrtd_pkg::run_t got;
		out_ch.ready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got.row    = out_ch.run_row;
				got.column = out_ch.run_column;
				got.length = out_ch.run_length;
				got.value  = out_ch.texel_value;
				got.done   = out_ch.frame_done;
				got.err    = out_ch.decode_error;
				tracker.match_run(got);
			end
			if (hold == 0 && !calm_sink && $urandom_range(0, 4) == 0) hold = pick_gap();
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Present one item, optionally after a gap, and hold it until it is taken.
	// Valid stays high on return so that back-to-back items follow without valid dropping in between.
	task automatic send_byte(input stream_byte_t it);
		int gap;
		gap = (!calm_src && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.data_byte   <= it.b;
		in_ch.frame_start <= it.fs;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		tracker.take_byte(it.b, it.fs);
		bytes_taken++;
	endtask

	// Drop valid and hold off until every predicted run has come out.
	task automatic drain_runs();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_runs.size() != 0) @(posedge clk);
	endtask

	// Drain, then give bytes that made no run time to clear the pipeline.
	task automatic settle();
		drain_runs();
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Write all four registers back to back; only called while the block is idle.
	task automatic write_all(input int w, input int h, input int key, input bit rle);
		rrtd_pkg::cfg_reg_t              idx[4];
		logic [rrtd_pkg::CFG_DATA_W-1:0] vals[4];
		int                              i;
		idx[0]  = rrtd_pkg::REG_WIDTH;
		idx[1]  = rrtd_pkg::REG_HEIGHT;
		idx[2]  = rrtd_pkg::REG_KEY;
		idx[3]  = rrtd_pkg::REG_MODE;
		vals[0] = rrtd_pkg::CFG_DATA_W'(w);
		vals[1] = rrtd_pkg::CFG_DATA_W'(h);
		vals[2] = rrtd_pkg::CFG_DATA_W'(key);
		vals[3] = rrtd_pkg::CFG_DATA_W'(rle);
		for (i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= vals[i];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
			tracker.set_reg(idx[i], vals[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic void push_byte(input int b, input bit fs = 1'b0);
		stream_byte_t s;
		s.b  = 8'(b);
		s.fs = fs;
		plan.push_back(s);
	endfunction

	// One compressed row: mostly well formed, sometimes empty, oversized,
	// running past the width or cut short mid-code.
	function automatic void plan_row(input int w);
		logic [7:0] codes[$];
		int         covered;
		int         style;
		int         n;
		int         count;
		int         reach;
		int         i;
		covered = 0;
		style = $urandom_range(0, 99);
		if (style < 5) begin
			push_byte(0);
			push_byte(0);
			return;
		end
		if (style < 8) begin
			count = $urandom_range(rrtd_pkg::MAX_ROW_BYTES + 1, 65535);
			push_byte(count & 255);
			push_byte(count >> 8);
			return;
		end
		reach = (style < 25) ? w + $urandom_range(1, 8) : w;
		while (covered < reach && codes.size() < 48) begin
			case ($urandom_range(0, 2))
			0: begin
				n = $urandom_range(0, (w < 127) ? w : 127);
				codes.push_back(8'((n << 1) | 1));
			end
			1: begin
				n = $urandom_range(1, (w < 64) ? w : 64);
				codes.push_back(8'(((n - 1) << 2) | 2));
				codes.push_back(8'($urandom));
			end
			default: begin
				n = $urandom_range(1, (w < 6) ? w : 6);
				codes.push_back(8'((n - 1) << 2));
				repeat (n) codes.push_back(8'($urandom));
			end
			endcase
			covered += n;
		end
		count = codes.size();
		if (style >= 25 && style < 40) count = $urandom_range(1, count);
		push_byte(count & 255);
		push_byte(count >> 8);
		for (i = 0; i < count; i++) push_byte(codes[i]);
	endfunction

	// A frame, marked on its first byte; tall frames are only begun.
	function automatic void plan_frame(input int w, input int h, input bit rle);
		int first;
		int rows;
		int total;
		int i;
		first = plan.size();
		if (rle) begin
			rows = (h <= 6) ? h : $urandom_range(1, 4);
			for (i = 0; i < rows; i++) plan_row(w);
		end else begin
			total = w * h;
			if (total > 48) total = $urandom_range(8, 48);
			for (i = 0; i < total; i++) push_byte($urandom);
		end
		if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_byte($urandom);
		plan[first].fs = 1'b1;
	endfunction

	function automatic void plan_noise();
		repeat ($urandom_range(1, 6)) push_byte($urandom, $urandom_range(0, 7) == 0);
	endfunction

	// Send the planned items; pause for a full drain at one point if asked.
	task automatic send_plan(input int pause_at);
		int i;
		for (i = 0; i < plan.size(); i++) begin
			if (i == pause_at) drain_runs();
			send_byte(plan[i]);
		end
		plan.delete();
	endtask

	initial begin
		int pick;
		int w;
		int h;
		int key;
		bit rle;
		int n;
		int i;
		int pause_at;
		bit first_random;

		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.data_byte   = 8'd0;
		in_ch.frame_start = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = rrtd_pkg::REG_WIDTH;
		cfg_ch.data       = '0;
		calm_src          = 1'b0;
		calm_sink         = 1'b0;
		bytes_taken       = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: width 8, two rows, compressed.
		write_all(8, 2, 8'hA5, 1'b1);
		// empty row: whole row as a key fill
		push_byte(8'h00, 1'b1);
		push_byte(8'h00);
		// six-byte row: skip three, zero skip, repeat one of 0xFF,
		// literal of two with only one byte left, then the key fill closes the frame
		push_byte(8'h06);
		push_byte(8'h00);
		push_byte(8'h07);
		push_byte(8'h01);
		push_byte(8'h02);
		push_byte(8'hFF);
		push_byte(8'h04);
		push_byte(8'h00);
		// frame complete: ignore this one
		push_byte(8'h55);
		// count just over the limit: error result, then ignore until a new frame
		push_byte(8'h01, 1'b1);
		push_byte(8'h20);
		// count at the limit is legal; the longest repeat is clipped, the rest drained
		push_byte(8'h00, 1'b1);
		push_byte(8'h20);
		push_byte(8'hFE);
		push_byte(8'h7A);
		push_byte(8'h03);
		// repeat code as the only byte of the row
		push_byte(8'h01, 1'b1);
		push_byte(8'h00);
		push_byte(8'h06);
		send_plan(-1);
		settle();

		// Directed: raw mode, two texels then one byte past the frame.
		write_all(2, 1, 0, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF);
		push_byte(8'hAA);
		send_plan(-1);
		settle();

		// Random phases: new settings, a few frames, noise in between.
		first_random = 1'b1;
		while (bytes_taken < ITEM_TARGET) begin
			pick = $urandom_range(0, 19);
			case (pick)
			0: begin
				w = rrtd_pkg::MAX_EDGE;
				h = rrtd_pkg::MAX_EDGE;
			end
			1: begin
				w = 1;
				h = 1;
			end
			2: begin
				// out of range both ways: read as one and as the largest edge
				w = 0;
				h = 2047;
			end
			3: begin
				w = rrtd_pkg::MAX_EDGE;
				h = $urandom_range(1, 3);
			end
			default: begin
				w = $urandom_range(1, 40);
				h = $urandom_range(1, 6);
			end
			endcase
			key = (pick == 0) ? 255 : (pick == 1) ? 0 : $urandom_range(0, 255);
			rle = ($urandom_range(0, 7) != 0);
			write_all(w, h, key, rle);
			calm_src  = ($urandom_range(0, 3) == 0);
			calm_sink = ($urandom_range(0, 3) == 0);

			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++) begin
				plan_frame(tracker.fit_edge(rrtd_pkg::CFG_DATA_W'(w)),
					tracker.fit_edge(rrtd_pkg::CFG_DATA_W'(h)), rle);
				if ($urandom_range(0, 5) == 0) plan_noise();
			end
			// now and then carry on the frame left open under the old settings
			if ($urandom_range(0, 3) == 0) plan[0].fs = 1'b0;

			pause_at = -1;
			if (first_random || $urandom_range(0, 3) == 0) begin
				pause_at = $urandom_range(plan.size() / 2, plan.size() - 1);
			end
			first_random = 1'b0;
			send_plan(pause_at);
			settle();
		end

		tracker.fails += tracker.pending_runs.size();
		if (tracker.fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- rle_row_texel_decoder_top.f -----
hw/rtl/rrtd_pkg.sv
hw/rtl/rrtd_in_if.sv
hw/rtl/rrtd_out_if.sv
hw/rtl/rrtd_cfg_if.sv
hw/rtl/rrtd_parser.sv
hw/rtl/rrtd_queue.sv
hw/rtl/rle_row_texel_decoder_top.sv
tb/sv/tb.sv
